/* src/imu_complementary_attitude_filter_unit_assert.svh */
// Assertion macros used by the attitude filter checker.
`ifndef IMU_COMPLEMENTARY_ATTITUDE_FILTER_UNIT_ASSERT_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_FILTER_UNIT_ASSERT_SVH
// Same-cycle implication, checked outside reset.
`define IMU_CAF_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imu_caf: assertion failed");
// Next-cycle implication, checked outside reset.
`define IMU_CAF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imu_caf: assertion failed");
`endif

/* src/imu_caf_pkg.sv */
// Types, constants and tables shared by the attitude filter modules.
package imu_caf_pkg;

  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int ANGLE_WIDTH_DEF  = 32;
  localparam int CORDIC_STEPS_DEF = 24;

  // CORDIC angle accumulator is Q.30; the rounded angle is Q.24.
  localparam int CORDIC_ZW   = 34;
  localparam int ACC_ANGLE_W = CORDIC_ZW - 6;

  localparam logic signed [CORDIC_ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

  localparam logic [2:0] CFG_FILTER_COEFF  = 3'd0;
  localparam logic [2:0] CFG_SAMPLE_PERIOD = 3'd1;
  localparam logic [2:0] CFG_GYRO_SCALE    = 3'd2;
  localparam logic [2:0] CFG_ACC_SCALE     = 3'd3;
  localparam logic [2:0] CFG_ROLL_ONLY     = 3'd4;

  localparam logic [15:0] FILTER_COEFF_RST  = 16'd49152;
  localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd4294967;
  localparam logic [31:0] GYRO_SCALE_RST    = 32'd2236;
  localparam logic [31:0] ACC_SCALE_RST     = 32'd4096;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_CRL_GO,
    ST_CRL_WAIT,
    ST_MAG,
    ST_CPT_GO,
    ST_CPT_WAIT,
    ST_BLEND,
    ST_FIN
  } state_t;

  // Multiplier operations in issue order.
  typedef enum logic [4:0] {
    OP_AY, OP_AZ, OP_AX, OP_GX, OP_GY, OP_GZ,
    OP_IH0, OP_IL0, OP_IH1, OP_IL1, OP_IH2, OP_IL2,
    OP_MH, OP_ML,
    OP_BKR, OP_BMR, OP_BKLR, OP_BMLR,
    OP_BKP, OP_BMP, OP_BKLP, OP_BMLP
  } op_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } cordic_ctl_t;

  typedef struct packed {
    logic valid;
    op_t  tag;
  } mul_ctl_t;

  // Arctangent of 2^-i in Q.30, rounded to nearest.
  function automatic logic [32:0] atan_q30(input int i);
    logic [32:0] r;
    case (i)
      0:  r = 33'd843314857;
      1:  r = 33'd497837829;
      2:  r = 33'd263043837;
      3:  r = 33'd133525159;
      4:  r = 33'd67021687;
      5:  r = 33'd33543516;
      6:  r = 33'd16775851;
      7:  r = 33'd8388437;
      8:  r = 33'd4194283;
      9:  r = 33'd2097149;
      10: r = 33'd1048576;
      default: begin
        if (i <= 30) r = 33'd1 << (30 - i);
        else r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

/* src/imu_caf_mul.sv */
// Registered signed multiplier that carries an operation tag with its product.
module imu_caf_mul
  import imu_caf_pkg::*;
#(
  parameter int MUL_W = 33
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mul_ctl_t                    req,
  input  logic signed [MUL_W-1:0]     op_a,
  input  logic signed [MUL_W-1:0]     op_b,
  output mul_ctl_t                    rsp,
  output logic signed [2*MUL_W-1:0]   prod
);

  mul_ctl_t                  rsp_r;
  logic signed [2*MUL_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_r <= '0;
    end else begin
      rsp_r <= req;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign rsp  = rsp_r;
  assign prod = prod_r;

endmodule

/* src/imu_caf_cordic_cell.sv */
// One CORDIC vectoring cell: a fixed shift and arctangent, registered outputs.
module imu_caf_cordic_cell
  import imu_caf_pkg::*;
#(
  parameter int CW = 50,
  parameter int SHIFT = 0,
  parameter logic signed [CORDIC_ZW-1:0] ATAN = '0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cordic_ctl_t                  ctl_in,
  input  logic signed [CW-1:0]         x_in,
  input  logic signed [CW-1:0]         y_in,
  input  logic signed [CORDIC_ZW-1:0]  z_in,
  output cordic_ctl_t                  ctl_out,
  output logic signed [CW-1:0]         x_out,
  output logic signed [CW-1:0]         y_out,
  output logic signed [CORDIC_ZW-1:0]  z_out
);

  cordic_ctl_t                 ctl_r;
  logic signed [CW-1:0]        x_r, y_r;
  logic signed [CORDIC_ZW-1:0] z_r;
  logic signed [CW-1:0]        dx, dy;

  assign dx = x_in >>> SHIFT;
  assign dy = y_in >>> SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  // Rotate toward the x axis: the sign of y picks the direction.
  always_ff @(posedge clk) begin
    if (!y_in[CW-1]) begin
      x_r <= x_in + dy;
      y_r <= y_in - dx;
      z_r <= z_in + ATAN;
    end else begin
      x_r <= x_in - dy;
      y_r <= y_in + dx;
      z_r <= z_in - ATAN;
    end
  end

  assign ctl_out = ctl_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign z_out   = z_r;

endmodule

/* src/imu_caf_cordic_chain.sv */
// Row of CORDIC cells computing atan2 and magnitude, with quadrant fold in front.
module imu_caf_cordic_chain
  import imu_caf_pkg::*;
#(
  parameter int CW = 50,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_v,
  input  logic signed [CW-1:0]           in_x,
  input  logic signed [CW-1:0]           in_y,
  output logic                           out_v,
  output logic [CW-1:0]                  out_mag,
  output logic signed [ACC_ANGLE_W-1:0]  out_angle
);

  cordic_ctl_t                 cs [CORDIC_STEPS+1];
  logic signed [CW-1:0]        xs [CORDIC_STEPS+1];
  logic signed [CW-1:0]        ys [CORDIC_STEPS+1];
  logic signed [CORDIC_ZW-1:0] zs [CORDIC_STEPS+1];
  logic signed [CORDIC_ZW-1:0] z_rnd;
  cordic_ctl_t                 ctl0;
  logic signed [CW-1:0]        x0, y0;
  logic signed [CORDIC_ZW-1:0] z0;

  // Vectors in the left half plane are turned by a quarter turn first.
  always_comb begin
    ctl0.valid = in_v;
    ctl0.zero  = (in_x == '0) && (in_y == '0);
    x0 = in_x;
    y0 = in_y;
    z0 = '0;
    if (in_x[CW-1]) begin
      if (!in_y[CW-1]) begin
        x0 = in_y;
        y0 = -in_x;
        z0 = HALF_PI_Q30;
      end else begin
        x0 = -in_y;
        y0 = in_x;
        z0 = -HALF_PI_Q30;
      end
    end
  end

  assign cs[0] = ctl0;
  assign xs[0] = x0;
  assign ys[0] = y0;
  assign zs[0] = z0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    imu_caf_cordic_cell #(
      .CW   (CW),
      .SHIFT(i),
      .ATAN (CORDIC_ZW'(atan_q30(i)))
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_in (cs[i]),
      .x_in   (xs[i]),
      .y_in   (ys[i]),
      .z_in   (zs[i]),
      .ctl_out(cs[i+1]),
      .x_out  (xs[i+1]),
      .y_out  (ys[i+1]),
      .z_out  (zs[i+1])
    );
  end

  assign z_rnd     = zs[CORDIC_STEPS] + CORDIC_ZW'(32);
  assign out_v     = cs[CORDIC_STEPS].valid;
  assign out_mag   = cs[CORDIC_STEPS].zero ? '0 : xs[CORDIC_STEPS];
  assign out_angle = cs[CORDIC_STEPS].zero ? '0 : z_rnd[CORDIC_ZW-1:6];

endmodule

/* src/imu_complementary_attitude_filter_unit.sv */
// One sample is in flight at a time: a new sample is taken only once the last
// result is registered, after two passes through the CORDIC cell row and the
// shared multiplier's 22 operations (one pass and 16 operations in roll-only mode).
// Reset (synchronous, active low) clears the angle state to zero and loads the
// register defaults; the finished result waits in an output register.
module imu_complementary_attitude_filter_unit
  import imu_caf_pkg::*;
#(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_acc_x,
  input  logic signed [SAMPLE_BITS-1:0] in_acc_y,
  input  logic signed [SAMPLE_BITS-1:0] in_acc_z,
  input  logic signed [SAMPLE_BITS-1:0] in_gyro_x,
  input  logic signed [SAMPLE_BITS-1:0] in_gyro_y,
  input  logic signed [SAMPLE_BITS-1:0] in_gyro_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [ANGLE_WIDTH-1:0] out_roll_angle,
  output logic signed [ANGLE_WIDTH-1:0] out_pitch_angle,
  output logic signed [ANGLE_WIDTH-1:0] out_yaw_angle,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int IW    = SAMPLE_BITS + 32;
  localparam int CW    = SAMPLE_BITS + 34;
  localparam int AW    = ((ANGLE_WIDTH > IW) ? ANGLE_WIDTH : IW) + 1;
  localparam int MUL_W = ((AW - 16) > 33) ? (AW - 16) : 33;
  localparam int SW    = AW + 2;
  localparam logic signed [SW:0] SAT_HI =
    $signed({{(SW + 2 - ANGLE_WIDTH){1'b0}}, {(ANGLE_WIDTH - 1){1'b1}}});
  localparam logic signed [SW:0] SAT_LO = ~SAT_HI;

  function automatic logic signed [ANGLE_WIDTH-1:0] sat_angle(input logic signed [SW:0] v);
    logic signed [ANGLE_WIDTH-1:0] r;
    if (v > SAT_HI) r = SAT_HI[ANGLE_WIDTH-1:0];
    else if (v < SAT_LO) r = SAT_LO[ANGLE_WIDTH-1:0];
    else r = v[ANGLE_WIDTH-1:0];
    return r;
  endfunction

  // Configuration.
  logic [15:0] filter_coeff_r;
  logic [31:0] sample_period_r, gyro_scale_r, acc_scale_r;
  logic        roll_only_r;

  // Control.
  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   accept, issue, feed_v, fin_load;
  logic   out_valid_r;

  // Angle state.
  logic signed [ANGLE_WIDTH-1:0] roll_est_r, pitch_est_r, yaw_est_r;

  // Working registers of one transaction.
  logic signed [SAMPLE_BITS-1:0] acc_x_r, acc_y_r, acc_z_r, gyro_x_r, gyro_y_r, gyro_z_r;
  logic signed [IW-1:0]          ax_r, ay_r, az_r;
  logic signed [IW-1:0]          rate_r [3];
  logic signed [IW-1:0]          inc_r [3];
  logic [CW-1:0]                 tmp_r, mag_r;
  logic signed [CW-1:0]          r_r;
  logic signed [ACC_ANGLE_W-1:0] acc_roll_r, acc_pitch_r;
  logic signed [SW-1:0]          s_r;
  logic [33:0]                   t_r;
  logic signed [ANGLE_WIDTH-1:0] out_roll_r, out_pitch_r, out_yaw_r;

  // Datapath.
  logic [IW-2:0]              rate_abs [3];
  logic signed [MUL_W-1:0]    op_a, op_b;
  mul_ctl_t                   mul_req, mul_rsp;
  logic signed [2*MUL_W-1:0]  prod;
  logic [CW-1:0]              hi_sum;
  logic signed [AW-1:0]       a_roll, a_pitch;
  logic signed [AW-17:0]      ha_roll, ha_pitch;
  logic signed [ACC_ANGLE_W-17:0] hc_roll, hc_pitch;
  logic [16:0]                m_coef;
  logic [34:0]                t_sum;
  logic signed [SW:0]         blend_sum, yaw_sum;
  logic signed [ANGLE_WIDTH-1:0] blend_val, yaw_nxt;
  logic                       chain_v;
  logic [CW-1:0]              chain_mag;
  logic signed [ACC_ANGLE_W-1:0] chain_angle;
  logic signed [CW-1:0]       feed_x, feed_y;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Next state and next operation.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_PRE;
          op_nxt    = OP_AY;
        end
      end
      ST_PRE: begin
        op_nxt = op_t'(op_r + 5'd1);
        if (op_r == OP_IL2) state_nxt = ST_CRL_GO;
      end
      ST_CRL_GO: state_nxt = ST_CRL_WAIT;
      ST_CRL_WAIT: begin
        if (chain_v) begin
          state_nxt = roll_only_r ? ST_BLEND : ST_MAG;
          op_nxt    = roll_only_r ? OP_BKR : OP_MH;
        end
      end
      ST_MAG: begin
        op_nxt = op_t'(op_r + 5'd1);
        if (op_r == OP_ML) state_nxt = ST_CPT_GO;
      end
      ST_CPT_GO: begin
        if (!mul_rsp.valid) state_nxt = ST_CPT_WAIT;
      end
      ST_CPT_WAIT: begin
        // From here both angles are blended, roll first.
        if (chain_v) begin
          state_nxt = ST_BLEND;
          op_nxt    = OP_BKR;
        end
      end
      ST_BLEND: begin
        op_nxt = op_t'(op_r + 5'd1);
        if ((op_r == OP_BMLR && roll_only_r) || op_r == OP_BMLP) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!mul_rsp.valid && (!out_valid_r || !out_stall)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State machine outputs.
  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    feed_v   = 1'b0;
    fin_load = 1'b0;
    case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_PRE, ST_MAG, ST_BLEND: issue = 1'b1;
      ST_CRL_GO: feed_v = 1'b1;
      ST_CPT_GO: feed_v = !mul_rsp.valid;
      ST_FIN:    fin_load = !mul_rsp.valid && (!out_valid_r || !out_stall);
      default:   in_stall = 1'b1;
    endcase
  end

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      rate_abs[n] = rate_r[n][IW-1] ? (IW-1)'(-rate_r[n]) : (IW-1)'(rate_r[n]);
    end
  end

  assign a_roll   = AW'(roll_est_r) + AW'(inc_r[0]);
  assign a_pitch  = AW'(pitch_est_r) + AW'(inc_r[1]);
  assign ha_roll  = a_roll[AW-1:16];
  assign ha_pitch = a_pitch[AW-1:16];
  assign hc_roll  = acc_roll_r[ACC_ANGLE_W-1:16];
  assign hc_pitch = acc_pitch_r[ACC_ANGLE_W-1:16];
  assign m_coef   = 17'h10000 - {1'b0, filter_coeff_r};

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (op_r)
      OP_AY:  begin op_a = MUL_W'(acc_y_r);  op_b = MUL_W'({1'b0, acc_scale_r}); end
      OP_AZ:  begin op_a = MUL_W'(acc_z_r);  op_b = MUL_W'({1'b0, acc_scale_r}); end
      OP_AX:  begin op_a = MUL_W'(acc_x_r);  op_b = MUL_W'({1'b0, acc_scale_r}); end
      OP_GX:  begin op_a = MUL_W'(gyro_x_r); op_b = MUL_W'({1'b0, gyro_scale_r}); end
      OP_GY:  begin op_a = MUL_W'(gyro_y_r); op_b = MUL_W'({1'b0, gyro_scale_r}); end
      OP_GZ:  begin op_a = MUL_W'(gyro_z_r); op_b = MUL_W'({1'b0, gyro_scale_r}); end
      OP_IH0: begin
        op_a = MUL_W'({1'b0, rate_abs[0][IW-2:32]});
        op_b = MUL_W'({1'b0, sample_period_r});
      end
      OP_IL0: begin
        op_a = MUL_W'({1'b0, rate_abs[0][31:0]});
        op_b = MUL_W'({1'b0, sample_period_r});
      end
      OP_IH1: begin
        op_a = MUL_W'({1'b0, rate_abs[1][IW-2:32]});
        op_b = MUL_W'({1'b0, sample_period_r});
      end
      OP_IL1: begin
        op_a = MUL_W'({1'b0, rate_abs[1][31:0]});
        op_b = MUL_W'({1'b0, sample_period_r});
      end
      OP_IH2: begin
        op_a = MUL_W'({1'b0, rate_abs[2][IW-2:32]});
        op_b = MUL_W'({1'b0, sample_period_r});
      end
      OP_IL2: begin
        op_a = MUL_W'({1'b0, rate_abs[2][31:0]});
        op_b = MUL_W'({1'b0, sample_period_r});
      end
      OP_MH:  begin
        op_a = MUL_W'({1'b0, mag_r[CW-2:32]});
        op_b = MUL_W'({1'b0, INV_GAIN_Q32});
      end
      OP_ML:  begin
        op_a = MUL_W'({1'b0, mag_r[31:0]});
        op_b = MUL_W'({1'b0, INV_GAIN_Q32});
      end
      OP_BKR:  begin op_a = MUL_W'(ha_roll);  op_b = MUL_W'({1'b0, filter_coeff_r}); end
      OP_BMR:  begin op_a = MUL_W'(hc_roll);  op_b = MUL_W'({1'b0, m_coef}); end
      OP_BKLR: begin
        op_a = MUL_W'({1'b0, a_roll[15:0]});
        op_b = MUL_W'({1'b0, filter_coeff_r});
      end
      OP_BMLR: begin
        op_a = MUL_W'({1'b0, acc_roll_r[15:0]});
        op_b = MUL_W'({1'b0, m_coef});
      end
      OP_BKP:  begin op_a = MUL_W'(ha_pitch); op_b = MUL_W'({1'b0, filter_coeff_r}); end
      OP_BMP:  begin op_a = MUL_W'(hc_pitch); op_b = MUL_W'({1'b0, m_coef}); end
      OP_BKLP: begin
        op_a = MUL_W'({1'b0, a_pitch[15:0]});
        op_b = MUL_W'({1'b0, filter_coeff_r});
      end
      OP_BMLP: begin
        op_a = MUL_W'({1'b0, acc_pitch_r[15:0]});
        op_b = MUL_W'({1'b0, m_coef});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_req.valid = issue;
  assign mul_req.tag   = op_r;

  imu_caf_mul #(
    .MUL_W(MUL_W)
  ) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .op_a (op_a),
    .op_b (op_b),
    .rsp  (mul_rsp),
    .prod (prod)
  );

  assign feed_x = (state_r == ST_CRL_GO) ? CW'(az_r) : r_r;
  assign feed_y = (state_r == ST_CRL_GO) ? CW'(ay_r) : -CW'(ax_r);

  imu_caf_cordic_chain #(
    .CW          (CW),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (feed_v),
    .in_x     (feed_x),
    .in_y     (feed_y),
    .out_v    (chain_v),
    .out_mag  (chain_mag),
    .out_angle(chain_angle)
  );

  // The low half of a split product adds its upper 32 bits to the high half.
  assign hi_sum    = tmp_r + CW'(prod[63:32]);
  assign t_sum     = {1'b0, t_r} + {1'b0, prod[33:0]};
  assign blend_sum = (SW+1)'(s_r) + (SW+1)'({1'b0, t_sum[34:16]});
  assign blend_val = sat_angle(blend_sum);
  assign yaw_sum   = (SW+1)'(yaw_est_r) + (SW+1)'(inc_r[2]);
  assign yaw_nxt   = sat_angle(yaw_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      op_r            <= OP_AY;
      out_valid_r     <= 1'b0;
      roll_est_r      <= '0;
      pitch_est_r     <= '0;
      yaw_est_r       <= '0;
      filter_coeff_r  <= FILTER_COEFF_RST;
      sample_period_r <= SAMPLE_PERIOD_RST;
      gyro_scale_r    <= GYRO_SCALE_RST;
      acc_scale_r     <= ACC_SCALE_RST;
      roll_only_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      if (fin_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (mul_rsp.valid && mul_rsp.tag == OP_BMLR) roll_est_r <= blend_val;
      if (mul_rsp.valid && mul_rsp.tag == OP_BMLP) pitch_est_r <= blend_val;
      if (fin_load && !roll_only_r) yaw_est_r <= yaw_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FILTER_COEFF:  filter_coeff_r  <= cfg_data[15:0];
          CFG_SAMPLE_PERIOD: sample_period_r <= cfg_data;
          CFG_GYRO_SCALE:    gyro_scale_r    <= cfg_data;
          CFG_ACC_SCALE:     acc_scale_r     <= cfg_data;
          CFG_ROLL_ONLY:     roll_only_r     <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_x_r  <= in_acc_x;
      acc_y_r  <= in_acc_y;
      acc_z_r  <= in_acc_z;
      gyro_x_r <= in_gyro_x;
      gyro_y_r <= in_gyro_y;
      gyro_z_r <= in_gyro_z;
    end
    if (chain_v && state_r == ST_CRL_WAIT) begin
      acc_roll_r <= chain_angle;
      mag_r      <= chain_mag;
    end
    if (chain_v && state_r == ST_CPT_WAIT) acc_pitch_r <= chain_angle;
    if (mul_rsp.valid) begin
      case (mul_rsp.tag)
        OP_AY:  ay_r <= prod[IW-1:0];
        OP_AZ:  az_r <= prod[IW-1:0];
        OP_AX:  ax_r <= prod[IW-1:0];
        OP_GX:  rate_r[0] <= prod[IW-1:0];
        OP_GY:  rate_r[1] <= prod[IW-1:0];
        OP_GZ:  rate_r[2] <= prod[IW-1:0];
        OP_IH0, OP_IH1, OP_IH2, OP_MH: tmp_r <= prod[CW-1:0];
        OP_IL0: inc_r[0] <= rate_r[0][IW-1] ? -IW'(hi_sum) : IW'(hi_sum);
        OP_IL1: inc_r[1] <= rate_r[1][IW-1] ? -IW'(hi_sum) : IW'(hi_sum);
        OP_IL2: inc_r[2] <= rate_r[2][IW-1] ? -IW'(hi_sum) : IW'(hi_sum);
        OP_ML:  r_r <= hi_sum;
        OP_BKR, OP_BKP: s_r <= prod[SW-1:0];
        OP_BMR, OP_BMP: s_r <= s_r + $signed(prod[SW-1:0]);
        OP_BKLR, OP_BKLP: t_r <= prod[33:0];
        default: ;
      endcase
    end
    if (fin_load) begin
      out_roll_r  <= roll_est_r;
      out_pitch_r <= pitch_est_r;
      out_yaw_r   <= roll_only_r ? yaw_est_r : yaw_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_roll_angle  = out_roll_r;
  assign out_pitch_angle = out_pitch_r;
  assign out_yaw_angle   = out_yaw_r;

endmodule

/* src/imu_caf_checker.sv */
// Port-level checker for the attitude filter and its bind to the top level.
`include "imu_complementary_attitude_filter_unit_assert.svh"

module imu_caf_checker #(
  parameter int ANGLE_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [ANGLE_WIDTH-1:0] out_roll_angle,
  input logic signed [ANGLE_WIDTH-1:0] out_pitch_angle,
  input logic signed [ANGLE_WIDTH-1:0] out_yaw_angle
);

  // A transaction keeps the input side closed until its result is registered.
  `IMU_CAF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // A new result only appears at the end of a transaction in progress.
  `IMU_CAF_ASSERT(a_result_from_busy, $rose(out_valid), $past(in_stall))

  `IMU_CAF_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid && $stable(out_roll_angle) && $stable(out_pitch_angle) && $stable(out_yaw_angle))

endmodule

bind imu_complementary_attitude_filter_unit imu_caf_checker #(
  .ANGLE_WIDTH(ANGLE_WIDTH)
) u_imu_caf_checker (.*);
